### rtl/core/iesb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sample buffer.
package iesb_pkg;

	// Fixed field widths.
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 31;
	localparam int POS_W   = 8;
	localparam int OP_W    = 2;
	localparam int CAP_RST = 256;

	// Error measure: 48 quotient bits plus one bit for the end-entry marker.
	localparam int ERR_W  = 49;
	localparam int Q_BITS = 48;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Read address sources.
	typedef enum logic [2:0] {
		AS_PREV,
		AS_CUR,
		AS_NEXT,
		AS_COPY,
		AS_POS
	} addr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      take;
		logic      init;
		logic      scan_init;
		addr_sel_t addr_sel;
		logic      rd_en;
		logic      lat_p;
		logic      lat_c;
		logic      lat_s;
		logic      div_start;
		logic      cmp_upd;
		logic      k_inc;
		logic      cp_init;
		logic      cp_wr;
		logic      ev_done;
		logic      push_wr;
		logic      out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            need_evict;
		logic            special;
		logic            scan_last;
		logic            cp_done;
		logic            span_bad;
		logic            div_done;
	} sts_t;

endpackage

### rtl/core/iesb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iesb_ram #(
	parameter int WIDTH = 47,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/iesb_div.sv
// Iterative restoring divider for the scaled interpolation error, one quotient bit per cycle.
module iesb_div #(
	parameter int N_W = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [N_W-1:0]           num,
	input  logic [31:0]              den,
	output logic                     done,
	output logic [iesb_pkg::ERR_W-1:0] quot
);

	localparam logic [iesb_pkg::ERR_W-1:0] SAT =
		{1'b0, {iesb_pkg::Q_BITS{1'b1}}};

	logic                        busy_q;
	logic                        done_q;
	logic [5:0]                  cnt_q;
	logic [31:0]                 rem_q;
	logic [iesb_pkg::Q_BITS-1:0] sh_q;
	logic [iesb_pkg::ERR_W-1:0]  quot_q;
	logic [32:0]                 trial;
	logic                        ge;
	logic                        sat;

	// The quotient reaches 2^48 exactly when num / 2^32 is at least den.
	assign sat   = (num >> 32) >= N_W'(den);
	assign trial = {rem_q, sh_q[iesb_pkg::Q_BITS-1]};
	assign ge    = trial >= {1'b0, den};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q  <= 6'(iesb_pkg::Q_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= 32'(num >> 32);
			sh_q   <= {num[31:0], 16'd0};
			quot_q <= sat ? SAT : '0;
		end else if (busy_q) begin
			rem_q  <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
			sh_q   <= {sh_q[iesb_pkg::Q_BITS-2:0], 1'b0};
			quot_q <= {quot_q[iesb_pkg::ERR_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### rtl/core/iesb_ctrl.sv
// Controller state machine: sequences push, eviction scan, compaction, read and clear.
module iesb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	input  iesb_pkg::sts_t  sts,
	output iesb_pkg::cmd_t  cmd
);

	typedef enum logic [18:0] {
		ST_IDLE  = 19'h00001,
		ST_DISP  = 19'h00002,
		ST_RP    = 19'h00004,
		ST_RC    = 19'h00008,
		ST_RS    = 19'h00010,
		ST_LS    = 19'h00020,
		ST_E1    = 19'h00040,
		ST_E2    = 19'h00080,
		ST_E3    = 19'h00100,
		ST_DIV   = 19'h00200,
		ST_DWAIT = 19'h00400,
		ST_CMP   = 19'h00800,
		ST_CPCHK = 19'h01000,
		ST_CPRD  = 19'h02000,
		ST_CPWR  = 19'h04000,
		ST_EVDN  = 19'h08000,
		ST_PUSH  = 19'h10000,
		ST_RDA   = 19'h20000,
		ST_OUT   = 19'h40000
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   m_tvalid_q;

	// Next state and command decode.
	always_comb begin
		nxt = state_q;
		cmd = '0;
		cmd.addr_sel = iesb_pkg::AS_CUR;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.take = 1'b1;
					nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (sts.op)
					iesb_pkg::OP_PUSH: begin
						if (sts.need_evict) begin
							cmd.scan_init = 1'b1;
							nxt = ST_RP;
						end else begin
							nxt = ST_PUSH;
						end
					end
					iesb_pkg::OP_READ: nxt = ST_RDA;
					iesb_pkg::OP_CLEAR: begin
						cmd.init = 1'b1;
						nxt = ST_OUT;
					end
					default: nxt = ST_OUT;
				endcase
			end
			ST_RP: begin
				cmd.addr_sel = iesb_pkg::AS_PREV;
				cmd.rd_en = 1'b1;
				nxt = ST_RC;
			end
			ST_RC: begin
				cmd.addr_sel = iesb_pkg::AS_CUR;
				cmd.rd_en = 1'b1;
				cmd.lat_p = 1'b1;
				nxt = ST_RS;
			end
			ST_RS: begin
				cmd.addr_sel = iesb_pkg::AS_NEXT;
				cmd.rd_en = 1'b1;
				cmd.lat_c = 1'b1;
				nxt = ST_LS;
			end
			ST_LS: begin
				cmd.lat_s = 1'b1;
				nxt = sts.special ? ST_CMP : ST_E1;
			end
			ST_E1: nxt = ST_E2;
			ST_E2: nxt = ST_E3;
			ST_E3: nxt = ST_DIV;
			ST_DIV: begin
				if (sts.span_bad) begin
					nxt = ST_CMP;
				end else begin
					cmd.div_start = 1'b1;
					nxt = ST_DWAIT;
				end
			end
			ST_DWAIT: begin
				if (sts.div_done) begin
					nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp_upd = 1'b1;
				if (sts.scan_last) begin
					cmd.cp_init = 1'b1;
					nxt = ST_CPCHK;
				end else begin
					cmd.k_inc = 1'b1;
					nxt = ST_RP;
				end
			end
			ST_CPCHK: nxt = sts.cp_done ? ST_EVDN : ST_CPRD;
			ST_CPRD: begin
				cmd.addr_sel = iesb_pkg::AS_COPY;
				cmd.rd_en = 1'b1;
				nxt = ST_CPWR;
			end
			ST_CPWR: begin
				cmd.cp_wr = 1'b1;
				nxt = ST_CPCHK;
			end
			ST_EVDN: begin
				cmd.ev_done = 1'b1;
				nxt = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push_wr = 1'b1;
				nxt = ST_OUT;
			end
			ST_RDA: begin
				cmd.addr_sel = iesb_pkg::AS_POS;
				cmd.rd_en = 1'b1;
				nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_axis_tready) begin
					cmd.out_load = 1'b1;
					nxt = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_tvalid_q;

endmodule

### rtl/core/iesb_dp.sv
// Datapath: sample store, counters, error pipeline, victim compare and result register.
module iesb_dp #(
	parameter int MAX_CAPACITY = 256,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [8:0]             cfg_wdata,
	input  logic [((2+SAMPLE_BITS+31+8+7)/8)*8-1:0]          s_tdata,
	output logic [((1+SAMPLE_BITS+31+1+31+9+32+7)/8)*8-1:0]  m_tdata,
	input  iesb_pkg::cmd_t         cmd,
	output iesb_pkg::sts_t         sts
);

	localparam int OUT_W  = ((1 + SAMPLE_BITS + 31 + 1 + 31 + 9 + 32 + 7) / 8) * 8;
	localparam int AW     = $clog2(MAX_CAPACITY);
	localparam int CW     = iesb_pkg::CNT_W;
	localparam int IW     = iesb_pkg::IDX_W;
	localparam int EW     = iesb_pkg::ERR_W;
	localparam int DX_W   = SAMPLE_BITS + 1;
	localparam int PROD_W = DX_W + 32;
	localparam int N_W    = PROD_W + 1;
	localparam int RAM_W  = IW + SAMPLE_BITS;
	localparam logic [CW-1:0] ACAP_RST = (MAX_CAPACITY < iesb_pkg::CAP_RST) ?
		CW'(MAX_CAPACITY) : CW'(iesb_pkg::CAP_RST);

	// Item and configuration registers.
	logic [iesb_pkg::OP_W-1:0]   op_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic [IW-1:0]               sidx_q;
	logic [iesb_pkg::POS_W-1:0]  pos_q;
	logic [8:0]                  cap_q;
	logic [CW-1:0]               acap_q;
	logic [CW-1:0]               count_q;
	logic [31:0]                 drop_q;
	logic [CW-1:0]               cap_eff;

	// Scan registers.
	logic [CW-1:0]               k_q;
	logic [CW-1:0]               end_q;
	logic [CW-1:0]               j_q;
	logic                        special_q;
	logic [CW-1:0]               victim_q;
	logic [EW-1:0]               best_q;
	logic [IW-1:0]               bidx_q;
	logic                        evicted_q;
	logic [IW-1:0]               evidx_q;
	logic                        sp;
	logic [CW-1:0]               k_start;

	// Neighbour window.
	logic signed [SAMPLE_BITS-1:0] xp_q, xc_q, xs_q;
	logic [IW-1:0]               ip_q, ic_q, is_q;

	// Error pipeline.
	logic signed [DX_W-1:0]      dxi_s1, dxs_s1;
	logic signed [31:0]          span_s1, di_s1;
	logic signed [PROD_W-1:0]    a_s2, b_s2;
	logic signed [31:0]          span_s2;
	logic signed [N_W-1:0]       diff;
	logic [N_W-1:0]              mag_s3;
	logic [31:0]                 span_s3;
	logic                        bad_s3;

	// Memory and divider signals.
	logic [RAM_W-1:0]            rd_data;
	logic [RAM_W-1:0]            wdata;
	logic [AW-1:0]               raddr, waddr;
	logic [CW-1:0]               rsel;
	logic                        div_done;
	logic [EW-1:0]               div_quot;
	logic [EW-1:0]               err_cur;
	logic                        upd;
	logic [CW-1:0]               victim_nx;
	logic                        rvalid;
	logic [SAMPLE_BITS-1:0]      rsamp;
	logic [IW-1:0]               ridx;

	// Capacity limited to the supported range.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (32'(cap_q) > MAX_CAPACITY) begin
			cap_eff = CW'(MAX_CAPACITY);
		end else begin
			cap_eff = cap_q;
		end
	end

	// With two or fewer entries every entry is a candidate, otherwise only the interior.
	assign sp      = count_q <= CW'(2);
	assign k_start = sp ? '0 : CW'(1);

	// Candidate error and victim choice.
	assign err_cur   = special_q ? '1 : (bad_s3 ? '0 : div_quot);
	assign upd       = (err_cur < best_q) || ((err_cur == best_q) && (ic_q < bidx_q));
	assign victim_nx = upd ? k_q : victim_q;

	// Read address selection.
	always_comb begin
		unique case (cmd.addr_sel)
			iesb_pkg::AS_PREV: rsel = k_q - CW'(1);
			iesb_pkg::AS_CUR:  rsel = k_q;
			iesb_pkg::AS_NEXT: rsel = k_q + CW'(1);
			iesb_pkg::AS_COPY: rsel = j_q + CW'(1);
			iesb_pkg::AS_POS:  rsel = CW'(pos_q);
			default:           rsel = k_q;
		endcase
	end
	assign raddr = AW'(rsel);
	assign waddr = cmd.cp_wr ? AW'(j_q) : AW'(count_q);
	assign wdata = cmd.cp_wr ? rd_data : {sidx_q, smp_q};

	iesb_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.cp_wr | cmd.push_wr),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rd_data)
	);

	iesb_div #(
		.N_W(N_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (mag_s3),
		.den   (span_s3),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Configuration and occupancy counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= 9'(iesb_pkg::CAP_RST);
			acap_q  <= ACAP_RST;
			count_q <= '0;
			drop_q  <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.init) begin
				acap_q  <= cap_eff;
				count_q <= '0;
				drop_q  <= '0;
			end else if (cmd.ev_done) begin
				count_q <= count_q - CW'(1);
				drop_q  <= drop_q + 32'd1;
			end else if (cmd.push_wr) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Item capture, scan state and neighbour window.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q      <= s_tdata[iesb_pkg::OP_W-1:0];
			smp_q     <= s_tdata[2 +: SAMPLE_BITS];
			sidx_q    <= s_tdata[2 + SAMPLE_BITS +: IW];
			pos_q     <= s_tdata[2 + SAMPLE_BITS + IW +: iesb_pkg::POS_W];
			evicted_q <= 1'b0;
			evidx_q   <= '0;
		end
		if (cmd.scan_init) begin
			special_q <= sp;
			k_q       <= k_start;
			end_q     <= sp ? count_q - CW'(1) : count_q - CW'(2);
			victim_q  <= k_start;
			best_q    <= '1;
			bidx_q    <= '1;
		end
		if (cmd.cmp_upd) begin
			victim_q <= victim_nx;
			if (upd) begin
				best_q <= err_cur;
				bidx_q <= ic_q;
			end
		end
		if (cmd.k_inc) begin
			k_q <= k_q + CW'(1);
		end
		if (cmd.cp_init) begin
			j_q <= victim_nx;
		end else if (cmd.cp_wr) begin
			j_q <= j_q + CW'(1);
		end
		if (cmd.ev_done) begin
			evicted_q <= 1'b1;
			evidx_q   <= bidx_q;
		end
		if (cmd.lat_p) begin
			xp_q <= rd_data[SAMPLE_BITS-1:0];
			ip_q <= rd_data[SAMPLE_BITS +: IW];
		end
		if (cmd.lat_c) begin
			xc_q <= rd_data[SAMPLE_BITS-1:0];
			ic_q <= rd_data[SAMPLE_BITS +: IW];
		end
		if (cmd.lat_s) begin
			xs_q <= rd_data[SAMPLE_BITS-1:0];
			is_q <= rd_data[SAMPLE_BITS +: IW];
		end
	end

	// Error pipeline: differences, products, magnitude of the cross difference.
	assign diff = N_W'(a_s2) - N_W'(b_s2);
	always_ff @(posedge clk) begin
		dxi_s1  <= DX_W'(xc_q) - DX_W'(xp_q);
		dxs_s1  <= DX_W'(xs_q) - DX_W'(xp_q);
		span_s1 <= $signed({1'b0, is_q}) - $signed({1'b0, ip_q});
		di_s1   <= $signed({1'b0, ic_q}) - $signed({1'b0, ip_q});
		a_s2    <= PROD_W'(dxi_s1) * PROD_W'(span_s1);
		b_s2    <= PROD_W'(di_s1) * PROD_W'(dxs_s1);
		span_s2 <= span_s1;
		mag_s3  <= diff[N_W-1] ? N_W'(-diff) : N_W'(diff);
		span_s3 <= span_s2;
		bad_s3  <= span_s2 <= 32'sd0;
	end

	// Result register.
	assign rvalid = (op_q == iesb_pkg::OP_READ) && (CW'(pos_q) < count_q);
	assign rsamp  = rvalid ? rd_data[SAMPLE_BITS-1:0] : '0;
	assign ridx   = rvalid ? rd_data[SAMPLE_BITS +: IW] : '0;
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= OUT_W'({drop_q, count_q, evidx_q, evicted_q, ridx, rsamp, rvalid});
		end
	end

	// Status to the controller.
	assign sts.op         = op_q;
	assign sts.need_evict = count_q >= acap_q;
	assign sts.special    = special_q;
	assign sts.scan_last  = k_q == end_q;
	assign sts.cp_done    = j_q >= count_q - CW'(1);
	assign sts.span_bad   = bad_s3;
	assign sts.div_done   = div_done;

endmodule

### rtl/core/interp_error_evicting_sample_buffer.sv
// Top level: interpolation-error evicting sample buffer, controller plus datapath.
// Clear and unknown ops go from dispatch to transfer to result; read and non-evicting push first
// pass a memory state. A push into a full buffer scans each candidate: previous, current and next
// entry reads, 3 error stages, a divider start, the one-bit-per-cycle divider and a compare, then
// a read and a write per entry moved to close the gap. One item is in work at a time.
// Reset (arst_n low) clears the buffer and sets capacity to 256; a clear op relatches it.
module interp_error_evicting_sample_buffer #(
	parameter int MAX_CAPACITY = 256,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [8:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// op, sample, sample_index, position
	input  logic [((2+SAMPLE_BITS+31+8+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// read_valid, read_sample, read_index, evicted, evicted_index, fill_count, drop_count
	output logic [((1+SAMPLE_BITS+31+1+31+9+32+7)/8)*8-1:0] m_axis_tdata
);

	iesb_pkg::cmd_t cmd;
	iesb_pkg::sts_t sts;

	iesb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	iesb_dp #(
		.MAX_CAPACITY(MAX_CAPACITY),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_axis_tdata),
		.m_tdata  (m_axis_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
